// File: hdl/sdss_pkg.sv
// ----------------------------------------------------------------------------
// sdss_pkg
// Shared types, widths and constants of the seven-segment display driver.
// ----------------------------------------------------------------------------
package sdss_pkg;

    localparam int unsigned COUNT_W    = 20;
    localparam int unsigned GRID_W     = 8;
    localparam int unsigned SEG_W      = 7;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned MAX_DIGITS = 8;
    localparam int unsigned RECIP_W    = 21;
    localparam int unsigned PROD_W     = COUNT_W + RECIP_W;

    // largest value a single decimal digit may take
    localparam logic [COUNT_W-1:0] DIGIT_MAX = COUNT_W'(9);
    localparam logic [SEG_W-1:0]   SEG_BLANK = '0;
    localparam logic [GRID_W-1:0]  GRID_ALL_OFF = '1;

    // count / 10^k == (count * RECIP_MUL[k]) >> RECIP_SHIFT[k] for any 20-bit count
    localparam logic [RECIP_W-1:0] RECIP_MUL [MAX_DIGITS] = '{
        21'd1048576, 21'd1677722, 21'd1342178, 21'd1073742,
        21'd1717987, 21'd1374390, 21'd1099512, 21'd1759219
    };
    localparam int unsigned RECIP_SHIFT [MAX_DIGITS] = '{
        20, 24, 27, 30, 34, 37, 40, 44
    };

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_stage_ctrl;

    // common-cathode code, gfedcba
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 7'h3f;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5b;
            4'd3:    code = 7'h4f;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6d;
            4'd6:    code = 7'h7d;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7f;
            4'd9:    code = 7'h6f;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/sdss_if.sv
// ----------------------------------------------------------------------------
// sdss_in_if / sdss_out_if
// Valid/ready channels of the display driver: commands in, scan words out.
// ----------------------------------------------------------------------------
interface sdss_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [19:0] count_value;

    modport source (output valid, output op, output count_value, input ready);
    modport sink   (input valid, input op, input count_value, output ready);
endinterface

interface sdss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] grid_byte;
    logic [6:0] segment_byte;

    modport source (output valid, output grid_byte, output segment_byte, input ready);
    modport sink   (input valid, input grid_byte, input segment_byte, output ready);
endinterface

// File: hdl/sdss_quot.sv
// ----------------------------------------------------------------------------
// sdss_quot
// Input register and decimal quotient stage: count / 10^k for every digit.
// ----------------------------------------------------------------------------
module sdss_quot
    import sdss_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sdss_in_if.sink            i_in,
    input  logic               i_ready,
    output t_stage_ctrl        o_ctrl,
    output logic [COUNT_W-1:0] o_quot [NUM_DIGITS]
);

    logic               r_s0_valid;
    t_op                r_s0_op;
    logic [COUNT_W-1:0] r_s0_count;

    logic               r_s1_valid;
    t_op                r_s1_op;
    logic [COUNT_W-1:0] r_quot [NUM_DIGITS];
    logic [COUNT_W-1:0] n_quot [NUM_DIGITS];

    logic s1_ready;

    assign s1_ready   = !r_s1_valid || i_ready;
    // no word is taken while reset is held
    assign i_in.ready = i_rst_n && (!r_s0_valid || s1_ready);

    // reciprocal multiply per digit, all independent
    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            prod      = PROD_W'(r_s0_count) * PROD_W'(RECIP_MUL[k]);
            n_quot[k] = COUNT_W'(prod >> RECIP_SHIFT[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s0_valid <= i_in.valid;
            end
            if (s1_ready) begin
                r_s1_valid <= r_s0_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s0_op    <= t_op'(i_in.op);
            r_s0_count <= i_in.count_value;
        end
        if (s1_ready && r_s0_valid) begin
            r_s1_op <= r_s0_op;
            r_quot  <= n_quot;
        end
    end

    assign o_ctrl.valid = r_s1_valid;
    assign o_ctrl.op    = r_s1_op;
    assign o_quot       = r_quot;

endmodule

// File: hdl/sdss_scan.sv
// ----------------------------------------------------------------------------
// sdss_scan
// Digit extraction, code store, scan pointer and output register.
// ----------------------------------------------------------------------------
module sdss_scan
    import sdss_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stage_ctrl        i_ctrl,
    input  logic [COUNT_W-1:0] i_quot [NUM_DIGITS],
    output logic               o_ready,
    sdss_out_if.source         o_out
);

    localparam int unsigned POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0]  POS_LAST = POS_W'(NUM_DIGITS - 1);
    localparam logic [GRID_W-1:0] TOP_BIT  = GRID_W'(1 << (NUM_DIGITS - 1));

    logic [SEG_W-1:0]  r_codes [NUM_DIGITS];
    logic [SEG_W-1:0]  n_codes [NUM_DIGITS];
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic              r_out_valid;
    logic [GRID_W-1:0] r_grid;
    logic [GRID_W-1:0] n_grid;
    logic [SEG_W-1:0]  r_seg;
    logic [SEG_W-1:0]  n_seg;

    logic             out_ready;
    logic             step;
    logic             load;
    logic [POS_W-1:0] cur_pos;

    assign out_ready = !r_out_valid || o_out.ready;
    assign o_ready   = out_ready;
    assign step      = i_ctrl.valid && out_ready;
    assign load      = (i_ctrl.op == OP_LOAD);

    // digit k = q[k] - 10*q[k+1]; the top digit is the whole remaining quotient
    always_comb begin
        logic [COUNT_W-1:0] diff;
        for (int k = 0; k < NUM_DIGITS - 1; k++) begin
            diff       = i_quot[k] - (i_quot[k+1] << 3) - (i_quot[k+1] << 1);
            n_codes[k] = seg_of(diff[DIGIT_W-1:0]);
        end
        if (i_quot[NUM_DIGITS-1] > DIGIT_MAX) begin
            n_codes[NUM_DIGITS-1] = SEG_BLANK;
        end else begin
            n_codes[NUM_DIGITS-1] = seg_of(i_quot[NUM_DIGITS-1][DIGIT_W-1:0]);
        end
    end

    always_comb begin
        cur_pos = load ? '0 : r_pos;
        n_seg   = load ? n_codes[0] : r_codes[r_pos];
        n_grid  = GRID_ALL_OFF ^ (TOP_BIT >> cur_pos);
        n_pos   = (cur_pos == POS_LAST) ? '0 : cur_pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_codes[k] <= SEG_BLANK;
            end
        end else begin
            if (out_ready) begin
                r_out_valid <= i_ctrl.valid;
            end
            if (step) begin
                r_pos <= n_pos;
                if (load) begin
                    r_codes <= n_codes;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_grid <= n_grid;
            r_seg  <= n_seg;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.grid_byte    = r_grid;
    assign o_out.segment_byte = r_seg;

endmodule

// File: hdl/six_digit_seven_segment_driver_unit.sv
// throughput: one command per cycle while the scan output is not stalled,
// set by the three-register pipeline
// (input register, per-digit reciprocal multiply, digit/code/scan stage)
// reset: synchronous, active low; clears the digit codes to blank and the
// scan pointer to the ones digit, and empties the pipeline
// ----------------------------------------------------------------------------
// six_digit_seven_segment_driver_unit
// Multiplexed decimal display driver: loads a binary count as seven-segment
// codes and scans one digit per tick with an active-low grid byte.
// ----------------------------------------------------------------------------
module six_digit_seven_segment_driver_unit
    import sdss_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdss_in_if.sink    i_in,
    sdss_out_if.source o_out
);

    t_stage_ctrl        quot_ctrl;
    logic [COUNT_W-1:0] quot [NUM_DIGITS];
    logic               scan_ready;

    sdss_quot #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (scan_ready),
        .o_ctrl  (quot_ctrl),
        .o_quot  (quot)
    );

    sdss_scan #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (quot_ctrl),
        .i_quot  (quot),
        .o_ready (scan_ready),
        .o_out   (o_out)
    );

endmodule

// File: hdl/sdss_checker.sv
// ----------------------------------------------------------------------------
// sdss_checker
// Port-level checks of the display driver, bound to the top level.
// ----------------------------------------------------------------------------
module sdss_checker
    import sdss_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 6
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [GRID_W-1:0] i_grid,
    input logic [SEG_W-1:0]  i_seg
);

    // grid bits above the configured digit count
    localparam logic [GRID_W-1:0] UNUSED = GRID_W'(16'hFF00 >> (GRID_W - NUM_DIGITS));

    // exactly one digit driven per word
    a_one_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($countones(~i_grid) == 1))
        else $error("grid byte does not select exactly one digit");

    a_unused_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_grid & UNUSED) == UNUSED))
        else $error("grid selects a digit beyond the display");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_grid) && $stable(i_seg)))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind six_digit_seven_segment_driver_unit sdss_checker #(
    .NUM_DIGITS (NUM_DIGITS)
) u_sdss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_grid      (o_out.grid_byte),
    .i_seg       (o_out.segment_byte)
);

// File: tb/sdss_scan_checker.sv
// ----------------------------------------------------------------------------
// sdss_scan_checker
// Watches the command and scan channels of the display driver, keeps its own
// copy of the digit codes and the scan pointer, and compares every scan word
// field by field with the one it predicts.
// ----------------------------------------------------------------------------
module sdss_scan_checker
    import sdss_pkg::*;
#(
    parameter int unsigned NUM_DIGITS = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sdss_in_if   i_cmd,
    sdss_out_if  i_scan,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [GRID_W-1:0] grid;
        logic [SEG_W-1:0]  seg;
    } t_scan_word;

    // common-cathode font, gfedcba
    localparam logic [SEG_W-1:0] DIGIT_FONT [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };

    logic [SEG_W-1:0] shown_codes [NUM_DIGITS];
    int unsigned      scan_pos;
    t_scan_word       pending_scans [$];

    function automatic logic [SEG_W-1:0] font_of(input int unsigned value);
        return (value > 9) ? SEG_BLANK : DIGIT_FONT[value];
    endfunction

    // updates the shadow display and returns the word the driver must put out
    function automatic t_scan_word predict_scan(input t_op op,
                                                input logic [COUNT_W-1:0] count);
        int unsigned rest;
        t_scan_word  word;
        rest = 32'(count);
        if (op == OP_LOAD) begin
            for (int k = 0; k < NUM_DIGITS - 1; k++) begin
                shown_codes[k] = font_of(rest % 10);
                rest = rest / 10;
            end
            // top digit keeps the remainder, blank above nine
            shown_codes[NUM_DIGITS-1] = font_of(rest);
            scan_pos = 0;
        end
        word.grid = GRID_ALL_OFF ^ (GRID_W'(1 << (NUM_DIGITS - 1)) >> scan_pos);
        word.seg  = shown_codes[scan_pos];
        scan_pos  = (scan_pos + 1 >= NUM_DIGITS) ? 0 : scan_pos + 1;
        return word;
    endfunction

    always @(posedge i_clk) begin
        t_scan_word want;
        if (!i_rst_n) begin
            foreach (shown_codes[k]) shown_codes[k] = SEG_BLANK;
            scan_pos = 0;
            pending_scans.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                pending_scans.push_back(predict_scan(t_op'(i_cmd.op), i_cmd.count_value));
            end
            if (i_scan.valid && i_scan.ready) begin
                if (pending_scans.size() == 0) begin
                    $display("%0t: scan word with none expected: grid %h seg %h",
                             $time, i_scan.grid_byte, i_scan.segment_byte);
                    o_fail_count++;
                end else begin
                    want = pending_scans.pop_front();
                    if (i_scan.grid_byte !== want.grid) begin
                        $display("%0t: grid_byte expected %h actual %h",
                                 $time, want.grid, i_scan.grid_byte);
                        o_fail_count++;
                    end
                    if (i_scan.segment_byte !== want.seg) begin
                        $display("%0t: segment_byte expected %h actual %h",
                                 $time, want.seg, i_scan.segment_byte);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = pending_scans.size();
    end

endmodule

// File: tb/six_digit_seven_segment_driver_unit_tb.sv
// ----------------------------------------------------------------------------
// six_digit_seven_segment_driver_unit_tb
// Drives load and tick commands into the display driver in random bursts,
// stalls the scan output on its own pattern, and lets the scan checker judge
// every word.
// ----------------------------------------------------------------------------
module six_digit_seven_segment_driver_unit_tb
    import sdss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_DIGITS      = 6;
    localparam int          CLK_PERIOD      = 12;
    localparam int          RESET_CYCLES    = 10;
    localparam int          RANDOM_ITEMS    = 400;
    localparam int          PAUSE_AT        = 260;
    localparam int          HOLD_AT         = 150;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          IDLE_LIMIT      = 4000;
    localparam int          DRAIN_CYCLES    = 8;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   burst_left;
    int   idle_cycles;

    sdss_in_if  cmd_ch ();
    sdss_out_if scan_ch ();

    six_digit_seven_segment_driver_unit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (scan_ch)
    );

    sdss_scan_checker #(
        .NUM_DIGITS (NUM_DIGITS)
    ) scan_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_scan       (scan_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return COUNT_W'($urandom_range(0, 99));
            1:       return COUNT_W'($urandom_range(999_000, 999_999));
            2:       return COUNT_W'($urandom_range(1_000_000, 1_048_575));
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input t_op op, input logic [COUNT_W-1:0] count);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.op          <= op;
        cmd_ch.count_value <= count;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // stimulus and verdict
    initial begin
        int n_ticks;
        int base_sent;
        logic paused;
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = OP_LOAD;
        cmd_ch.count_value = '0;
        items_sent         = 0;
        burst_left         = 0;
        paused             = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ticks before any load scan the blank reset codes
        send_word(OP_TICK, '1);
        send_word(OP_TICK, '0);
        send_word(OP_LOAD, COUNT_W'(0));
        send_word(OP_LOAD, COUNT_W'(123456));
        // full scan plus wrap back to the ones digit
        repeat (6) send_word(OP_TICK, COUNT_W'($urandom));
        send_word(OP_LOAD, COUNT_W'(999999));
        // top digit of ten shows blank
        send_word(OP_LOAD, COUNT_W'(1000000));
        repeat (5) send_word(OP_TICK, COUNT_W'($urandom));
        send_word(OP_LOAD, '1);
        send_word(OP_TICK, '0);
        send_word(OP_LOAD, COUNT_W'(20'h80000));
        send_word(OP_LOAD, COUNT_W'(100000));
        send_word(OP_LOAD, COUNT_W'(7));
        repeat (2) send_word(OP_TICK, '1);

        // loads each followed by a partial, full or wrapping scan, with one pause to drain
        base_sent = items_sent;
        while (items_sent - base_sent < RANDOM_ITEMS) begin
            if (!paused && items_sent - base_sent >= PAUSE_AT) begin
                paused = 1'b1;
                cmd_ch.valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
                burst_left = 0;
            end
            send_word(OP_LOAD, pick_count());
            n_ticks = $urandom_range(0, 13);
            repeat (n_ticks) send_word(OP_TICK, COUNT_W'($urandom));
        end
        cmd_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // scan output stalls, with one long hold-off while commands keep coming
    initial begin
        int rx_cycle;
        int rx_mode;
        logic hold_done;
        logic rdy;
        rx_cycle      = 0;
        rx_mode       = 0;
        hold_done     = 1'b0;
        scan_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                scan_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = ($urandom_range(0, 4) != 0);
                default: rdy = ((rx_cycle % 5) < 3);
            endcase
            scan_ch.ready <= rdy;
        end
    end

    // ends the run when neither channel moves a word for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (scan_ch.valid && scan_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
